### sv/lcpf_pkg.sv
// Shared constants and types for the Lennard-Jones cutoff pair force block.
// No dependencies; the front, back, top level and testbench refer to it by scoped names.
`default_nettype none
package lcpf_pkg;

	localparam int POS_W = 32;
	localparam int MAG_W = 32;
	localparam int R2_W = 50;
	// last, cutoff flag, three sign bits, three magnitudes and r2
	localparam int ITEM_FIX_W = 5 + 3 * MAG_W + R2_W;

	localparam logic [7:0] CFG_EPSILON = 8'd0;
	localparam logic [7:0] CFG_SIGMA_POW6 = 8'd1;
	localparam logic [7:0] CFG_CUTOFF_SQ = 8'd2;
	localparam logic [7:0] CFG_HALF_LIST = 8'd3;

	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] ONE_Q16 = 64'h0000_0000_0001_0000;
	localparam logic [63:0] K24_LIM = 64'hFFFF_FFFF_FFFF_FFFF / 64'd24;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_CHK  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_SHF  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	// one operation of the shared multiply/divide unit
	typedef enum logic [3:0] {
		OP_U1 = 4'd0,
		OP_U2 = 4'd1,
		OP_T  = 4'd2,
		OP_W  = 4'd3,
		OP_K  = 4'd4,
		OP_F0 = 4'd5,
		OP_F1 = 4'd6,
		OP_F2 = 4'd7,
		OP_V  = 4'd8,
		OP_E  = 4'd9
	} op_t;

endpackage
`default_nettype wire

### sv/lcpf_ifs.sv
// Channel interfaces: pair input, result output and configuration write.
// Depends on nothing but the parameters passed in.
`default_nettype none
interface lcpf_pair_if #(parameter int INDEX_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    atom_x;
	logic signed [31:0]    atom_y;
	logic signed [31:0]    atom_z;
	logic signed [31:0]    nb_x;
	logic signed [31:0]    nb_y;
	logic signed [31:0]    nb_z;
	logic [INDEX_BITS-1:0] nb_index;
	logic                  last_neighbour;
	modport source (output valid, atom_x, atom_y, atom_z, nb_x, nb_y, nb_z, nb_index,
		last_neighbour, input ready);
	modport sink (input valid, atom_x, atom_y, atom_z, nb_x, nb_y, nb_z, nb_index,
		last_neighbour, output ready);
endinterface

interface lcpf_res_if #(parameter int INDEX_BITS = 16, parameter int ACC_WIDTH = 48);
	logic                        valid;
	logic                        ready;
	logic [INDEX_BITS-1:0]       out_nb_index;
	logic signed [ACC_WIDTH-1:0] react_fx;
	logic signed [ACC_WIDTH-1:0] react_fy;
	logic signed [ACC_WIDTH-1:0] react_fz;
	logic signed [ACC_WIDTH-1:0] pair_energy;
	logic                        react_valid;
	logic signed [ACC_WIDTH-1:0] total_fx;
	logic signed [ACC_WIDTH-1:0] total_fy;
	logic signed [ACC_WIDTH-1:0] total_fz;
	logic signed [ACC_WIDTH-1:0] total_energy;
	logic                        atom_done;
	modport source (output valid, out_nb_index, react_fx, react_fy, react_fz, pair_energy,
		react_valid, total_fx, total_fy, total_fz, total_energy, atom_done, input ready);
	modport sink (input valid, out_nb_index, react_fx, react_fy, react_fz, pair_energy,
		react_valid, total_fx, total_fy, total_fz, total_energy, atom_done, output ready);
endinterface

interface lcpf_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/lcpf_fifo.sv
// Two-entry queue between the classifying front and the force back end.
// Generic payload width; no package dependencies.
`default_nettype none
module lcpf_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty
);
	logic [W-1:0] mem [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

### sv/lcpf_front.sv
// Front end: takes pair items, forms distance magnitudes, r2 and the cutoff test.
// Uses lcpf_pkg and lcpf_pair_if; pushes packed items into the queue.
`default_nettype none
module lcpf_front #(
	parameter int INDEX_BITS = 16,
	parameter int IW = INDEX_BITS + lcpf_pkg::ITEM_FIX_W
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lcpf_pair_if.sink        in,
	input  wire logic [47:0] cutoff_sq,
	output logic             push,
	output logic [IW-1:0]    push_data,
	input  wire logic        full
);
	logic [lcpf_pkg::POS_W:0]     d   [3];
	logic [lcpf_pkg::MAG_W-1:0]   mag [3];
	logic [2:0]                   dneg;
	logic [63:0]                  sq  [3];
	logic [65:0]                  ssum;
	logic [lcpf_pkg::R2_W-1:0]    r2;
	logic                         in_cut;
	logic                         v_s1;
	logic [IW-1:0]                item_s1;

	always_comb begin
		d[0] = {in.nb_x[31], in.nb_x} - {in.atom_x[31], in.atom_x};
		d[1] = {in.nb_y[31], in.nb_y} - {in.atom_y[31], in.atom_y};
		d[2] = {in.nb_z[31], in.nb_z} - {in.atom_z[31], in.atom_z};
		for (int i = 0; i < 3; i++) begin
			dneg[i] = d[i][lcpf_pkg::POS_W];
			mag[i] = dneg[i] ? lcpf_pkg::MAG_W'(-d[i]) : lcpf_pkg::MAG_W'(d[i]);
			sq[i] = mag[i] * mag[i];
		end
		ssum = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
		r2 = ssum[65:16];
		in_cut = (r2 != '0) && (r2 <= {2'b00, cutoff_sq});
	end

	assign in.ready = !v_s1 || !full;
	assign push = v_s1;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in.ready) begin
			v_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			item_s1 <= {in.nb_index, in.last_neighbour, in_cut, dneg,
				mag[2], mag[1], mag[0], r2};
		end
	end
endmodule
`default_nettype wire

### sv/lcpf_back.sv
// Back end: shared bit-serial multiply / divide unit that evaluates the LJ terms,
// saturating accumulation and the output register. Uses lcpf_pkg, lcpf_res_if.
`default_nettype none
module lcpf_back #(
	parameter int INDEX_BITS = 16,
	parameter int ACC_WIDTH = 48,
	parameter int IW = INDEX_BITS + lcpf_pkg::ITEM_FIX_W
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] epsilon,
	input  wire logic [47:0] sigma_pow6,
	input  wire logic        half_list,
	input  wire logic [IW-1:0] pop_data,
	input  wire logic        empty,
	output logic             pop,
	lcpf_res_if.source       out
);
	localparam int RW = lcpf_pkg::R2_W;
	localparam int MW = lcpf_pkg::MAG_W;
	localparam logic [63:0] ACC_MAX = 64'((65'd1 << (ACC_WIDTH - 1)) - 65'd1);

	lcpf_pkg::state_t st_q;
	lcpf_pkg::op_t    op_q;
	logic [63:0] hi_q, lo_q, b_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q, t_q, k_q;
	logic [63:0] fm_q [3];
	logic [IW-1:0] item_q;
	logic ov_q;
	logic [ACC_WIDTH-1:0] sum_q [4];

	logic [INDEX_BITS-1:0] idx;
	logic last, in_cut;
	logic [2:0] dneg;
	logic [MW-1:0] mag [3];
	logic [RW-1:0] r2;
	logic [63:0] a_sel, b_sel;
	logic [63:0] hmag, emag, t2;
	logic hneg, eneg;
	logic [64:0] msum, dx, dxs;
	logic dge;
	logic [127:0] shv;
	logic [63:0] shr;
	logic shov;
	logic is_div, out_free, fire;
	logic [ACC_WIDTH-1:0] pf [4];
	logic [ACC_WIDTH-1:0] ns [4];

	function automatic logic [ACC_WIDTH-1:0] ssat(input logic [63:0] m, input logic neg);
		logic [63:0] mc;
		mc = (m > ACC_MAX) ? ACC_MAX : m;
		return neg ? ACC_WIDTH'(-mc) : ACC_WIDTH'(mc);
	endfunction

	function automatic logic [ACC_WIDTH-1:0] add_sat(input logic [ACC_WIDTH-1:0] a,
		input logic [ACC_WIDTH-1:0] b);
		logic [ACC_WIDTH:0] s;
		s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
			return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end
		return s[ACC_WIDTH-1:0];
	endfunction

	assign {idx, last, in_cut, dneg, mag[2], mag[1], mag[0], r2} = item_q;

	always_comb begin
		// force and energy factors from t
		t2 = {t_q[62:0], 1'b0};
		if (t_q[63]) begin
			hmag = '1;
			hneg = 1'b0;
		end else if (t2 >= lcpf_pkg::ONE_Q32) begin
			hmag = t2 - lcpf_pkg::ONE_Q32;
			hneg = 1'b0;
		end else begin
			hmag = lcpf_pkg::ONE_Q32 - t2;
			hneg = 1'b1;
		end
		eneg = t_q < lcpf_pkg::ONE_Q32;
		emag = eneg ? lcpf_pkg::ONE_Q32 - t_q : t_q - lcpf_pkg::ONE_Q32;

		is_div = 1'b0;
		case (op_q)
			lcpf_pkg::OP_U1: begin
				a_sel = {16'd0, sigma_pow6};
				b_sel = lcpf_pkg::ONE_Q32;
				is_div = 1'b1;
			end
			lcpf_pkg::OP_U2, lcpf_pkg::OP_T: begin
				a_sel = x_q;
				b_sel = lcpf_pkg::ONE_Q16;
				is_div = 1'b1;
			end
			lcpf_pkg::OP_W: begin
				a_sel = t_q;
				b_sel = hmag;
			end
			lcpf_pkg::OP_K, lcpf_pkg::OP_E: begin
				a_sel = {32'd0, epsilon};
				b_sel = x_q;
			end
			lcpf_pkg::OP_F0: begin
				a_sel = k_q;
				b_sel = {32'd0, mag[0]};
				is_div = 1'b1;
			end
			lcpf_pkg::OP_F1: begin
				a_sel = k_q;
				b_sel = {32'd0, mag[1]};
				is_div = 1'b1;
			end
			lcpf_pkg::OP_F2: begin
				a_sel = k_q;
				b_sel = {32'd0, mag[2]};
				is_div = 1'b1;
			end
			lcpf_pkg::OP_V: begin
				a_sel = t_q;
				b_sel = emag;
			end
			default: begin
				a_sel = '0;
				b_sel = '0;
			end
		endcase

		msum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : 65'd0);

		dx = {hi_q, lo_q[63]};
		dge = dx >= {15'd0, r2};
		dxs = dge ? dx - {15'd0, r2} : dx;

		case (op_q)
			lcpf_pkg::OP_K: begin
				shv = {hi_q, lo_q} >> 16;
				shov = (hi_q >> 16) != '0;
			end
			lcpf_pkg::OP_E: begin
				shv = {hi_q, lo_q} >> 15;
				shov = (hi_q >> 15) != '0;
			end
			default: begin
				shv = {hi_q, lo_q} >> 40;
				shov = (hi_q >> 40) != '0;
			end
		endcase
		shr = shov ? '1 : shv[63:0];

		for (int i = 0; i < 3; i++) begin
			pf[i] = in_cut ? ssat(fm_q[i], hneg == dneg[i]) : '0;
		end
		// energy magnitude is read straight from the unit while finishing the last op
		pf[3] = in_cut ? ssat(lo_q, eneg) : '0;
		for (int i = 0; i < 4; i++) begin
			ns[i] = in_cut ? add_sat(sum_q[i], pf[i]) : sum_q[i];
		end
	end

	assign out_free = !ov_q || out.ready;
	assign fire = (st_q == lcpf_pkg::ST_FIN) && (!in_cut || op_q == lcpf_pkg::OP_E)
		&& out_free;
	assign pop = (st_q == lcpf_pkg::ST_IDLE) && !empty;
	assign out.valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lcpf_pkg::ST_IDLE;
			op_q <= lcpf_pkg::OP_U1;
			ov_q <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			ov_q <= fire || (ov_q && !out.ready);
			case (st_q)
				lcpf_pkg::ST_IDLE: begin
					if (!empty) begin
						op_q <= lcpf_pkg::OP_U1;
						st_q <= pop_data[IW-INDEX_BITS-2] ? lcpf_pkg::ST_LOAD
							: lcpf_pkg::ST_FIN;
					end
				end
				lcpf_pkg::ST_LOAD: begin
					cnt_q <= '0;
					st_q <= lcpf_pkg::ST_MUL;
				end
				lcpf_pkg::ST_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						st_q <= is_div ? lcpf_pkg::ST_CHK : lcpf_pkg::ST_SHF;
					end
				end
				lcpf_pkg::ST_CHK: begin
					cnt_q <= '0;
					st_q <= (hi_q >= {14'd0, r2}) ? lcpf_pkg::ST_FIN : lcpf_pkg::ST_DIV;
				end
				lcpf_pkg::ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						st_q <= lcpf_pkg::ST_FIN;
					end
				end
				lcpf_pkg::ST_SHF: begin
					st_q <= lcpf_pkg::ST_FIN;
				end
				lcpf_pkg::ST_FIN: begin
					if (!in_cut || op_q == lcpf_pkg::OP_E) begin
						// hold until the output register frees up
						if (out_free) begin
							for (int i = 0; i < 4; i++) begin
								sum_q[i] <= last ? '0 : ns[i];
							end
							st_q <= lcpf_pkg::ST_IDLE;
						end
					end else begin
						op_q <= lcpf_pkg::op_t'(op_q + 4'd1);
						st_q <= lcpf_pkg::ST_LOAD;
					end
				end
				default: st_q <= lcpf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			lcpf_pkg::ST_IDLE: begin
				if (!empty) begin
					item_q <= pop_data;
				end
			end
			lcpf_pkg::ST_LOAD: begin
				hi_q <= '0;
				lo_q <= a_sel;
				b_q <= b_sel;
			end
			lcpf_pkg::ST_MUL: begin
				hi_q <= msum[64:1];
				lo_q <= {msum[0], lo_q[63:1]};
			end
			lcpf_pkg::ST_CHK: begin
				if (hi_q >= {14'd0, r2}) begin
					lo_q <= '1;
				end
			end
			lcpf_pkg::ST_DIV: begin
				hi_q <= dxs[63:0];
				lo_q <= {lo_q[62:0], dge};
			end
			lcpf_pkg::ST_SHF: begin
				lo_q <= shr;
			end
			lcpf_pkg::ST_FIN: begin
				if (in_cut) begin
					case (op_q)
						lcpf_pkg::OP_U1, lcpf_pkg::OP_U2, lcpf_pkg::OP_W,
						lcpf_pkg::OP_V: x_q <= lo_q;
						lcpf_pkg::OP_T: t_q <= lo_q;
						lcpf_pkg::OP_K: k_q <= (lo_q > lcpf_pkg::K24_LIM) ? '1
							: (lo_q << 4) + (lo_q << 3);
						lcpf_pkg::OP_F0: fm_q[0] <= lo_q;
						lcpf_pkg::OP_F1: fm_q[1] <= lo_q;
						lcpf_pkg::OP_F2: fm_q[2] <= lo_q;
						default: x_q <= lo_q;
					endcase
				end
				if (fire) begin
					out.out_nb_index <= idx;
					out.react_valid <= in_cut && half_list;
					out.react_fx <= (in_cut && half_list) ? pf[0] : '0;
					out.react_fy <= (in_cut && half_list) ? pf[1] : '0;
					out.react_fz <= (in_cut && half_list) ? pf[2] : '0;
					out.pair_energy <= pf[3];
					out.total_fx <= ns[0];
					out.total_fy <= ns[1];
					out.total_fz <= ns[2];
					out.total_energy <= ns[3];
					out.atom_done <= last;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

### sv/lj_cutoff_pair_force.sv
// Lennard-Jones 12-6 cutoff pair force, one result per accepted pair.
// Inside the cutoff a pair takes ten 64-bit shift-add multiplies, six of them followed by
// a 64-step restoring divide unless the quotient saturates; a pair outside skips them all.
// The single shared multiply/divide unit takes no new pair until it is done with the last;
// the front register and two-entry queue take up to three further pairs meanwhile.
// Reset (arst_n low) empties all stages, restores register defaults, zeroes the totals.
`default_nettype none
module lj_cutoff_pair_force #(
	parameter int INDEX_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lcpf_pair_if.sink  in,
	lcpf_res_if.source out,
	lcpf_cfg_if.sink   cfg
);
	localparam int IW = INDEX_BITS + lcpf_pkg::ITEM_FIX_W;

	logic [31:0]   eps_q;
	logic [47:0]   s6_q;
	logic [47:0]   cut_q;
	logic          half_q;
	logic          push, full, pop, empty;
	logic [IW-1:0] push_data, pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 32'd65536;
			s6_q <= 48'd65536;
			cut_q <= 48'd409600;
			half_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				lcpf_pkg::CFG_EPSILON: eps_q <= cfg.data[31:0];
				lcpf_pkg::CFG_SIGMA_POW6: s6_q <= cfg.data[47:0];
				lcpf_pkg::CFG_CUTOFF_SQ: cut_q <= cfg.data[47:0];
				lcpf_pkg::CFG_HALF_LIST: half_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	lcpf_front #(.INDEX_BITS(INDEX_BITS), .IW(IW)) u_front (
		.clk(clk), .arst_n(arst_n), .in(in), .cutoff_sq(cut_q),
		.push(push), .push_data(push_data), .full(full)
	);

	lcpf_fifo #(.W(IW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	lcpf_back #(.INDEX_BITS(INDEX_BITS), .ACC_WIDTH(ACC_WIDTH), .IW(IW)) u_back (
		.clk(clk), .arst_n(arst_n), .epsilon(eps_q), .sigma_pow6(s6_q),
		.half_list(half_q), .pop_data(pop_data), .empty(empty), .pop(pop), .out(out)
	);
endmodule
`default_nettype wire

### sv/lcpf_chk.sv
// Port-level checker for lj_cutoff_pair_force, attached by the bind at the end.
// Depends only on the top level's ports.
`default_nettype none
module lcpf_chk #(
	parameter int INDEX_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic                 react_valid,
	input wire logic                 atom_done,
	input wire logic [ACC_WIDTH-1:0] react_fx,
	input wire logic [ACC_WIDTH-1:0] react_fy,
	input wire logic [ACC_WIDTH-1:0] react_fz,
	input wire logic [ACC_WIDTH-1:0] pair_energy,
	input wire logic [ACC_WIDTH-1:0] total_fx,
	input wire logic [ACC_WIDTH-1:0] total_energy,
	input wire logic [INDEX_BITS-1:0] out_nb_index
);
	logic [3:0] pend_q;
	logic       fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			fresh_q <= 1'b1;
		end else begin
			pend_q <= pend_q + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
			if (out_valid && out_ready) begin
				fresh_q <= atom_done;
			end
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0) else $error("result without pending pair");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd5) else $error("more pairs in flight than storage");

	a_react_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !react_valid |-> react_fx == '0 && react_fy == '0 && react_fz == '0)
		else $error("reaction force without valid flag");

	a_first_total: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q && out_valid && react_valid |-> total_fx == react_fx
			&& total_energy == pair_energy)
		else $error("totals not cleared after last neighbour");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_nb_index) && $stable(total_fx))
		else $error("stalled result changed");
endmodule

bind lj_cutoff_pair_force lcpf_chk #(.INDEX_BITS(INDEX_BITS), .ACC_WIDTH(ACC_WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .react_valid(out.react_valid),
	.atom_done(out.atom_done), .react_fx(out.react_fx), .react_fy(out.react_fy),
	.react_fz(out.react_fz), .pair_energy(out.pair_energy), .total_fx(out.total_fx),
	.total_energy(out.total_energy), .out_nb_index(out.out_nb_index)
);
`default_nettype wire

### dv/lj_cutoff_pair_force_test.sv
// Self-checking testbench for lj_cutoff_pair_force: random neighbour pairs over several
// register settings, each result checked against an in-line fixed-point force predictor.
// Depends on lcpf_pkg and the channel interfaces in lcpf_ifs.sv.
`default_nettype none
module lj_cutoff_pair_force_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ACC_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam int SPAN = 196608;

	typedef struct {
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [15:0] idx;
		logic last;
	} pair_t;

	typedef struct packed {
		logic [15:0] idx;
		logic [47:0] rfx, rfy, rfz, energy;
		logic rvalid;
		logic [47:0] tfx, tfy, tfz, tenergy;
		logic done;
	} force_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lcpf_pair_if #(.INDEX_BITS(16)) pin();
	lcpf_res_if #(.INDEX_BITS(16), .ACC_WIDTH(48)) res();
	lcpf_cfg_if cfgw();

	lj_cutoff_pair_force #(.INDEX_BITS(16), .ACC_WIDTH(48)) DUT (
		.clk(clk), .arst_n(arst_n), .in(pin.sink), .out(res.source), .cfg(cfgw.sink)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register shadow and atom force totals
	logic [31:0] eps_q = 32'd65536;
	logic [47:0] s6_q = 48'd65536;
	logic [47:0] cut_q = 48'd409600;
	logic half_q = 1'b0;
	logic signed [47:0] sum_fx = '0, sum_fy = '0, sum_fz = '0, sum_e = '0;

	pair_t pending_pairs[$];
	force_res_t expected_forces[$];
	int mismatches = 0;

	function automatic logic [63:0] div_sat(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [127:0] p;
		if (c == 0)
			return '1;
		p = {64'b0, a} * {64'b0, b};
		if (p[127:64] >= c)
			return '1;
		return 64'(p / {64'b0, c});
	endfunction

	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = ({64'b0, a} * {64'b0, b}) >> s;
		if (p[127:64] != 0)
			return '1;
		return p[63:0];
	endfunction

	function automatic logic [47:0] sat_acc(logic [63:0] mag, logic neg);
		logic [47:0] m;
		m = (mag > ACC_MAX) ? ACC_MAX[47:0] : mag[47:0];
		return neg ? -m : m;
	endfunction

	function automatic logic signed [47:0] add_sat(logic signed [47:0] a, logic signed [47:0] b);
		logic [48:0] s;
		s = {a[47], a} + {b[47], b};
		if (s[48] != s[47])
			return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		return s[47:0];
	endfunction

	function automatic force_res_t pair_force(pair_t p);
		logic signed [32:0] d[3];
		logic [63:0] m[3];
		logic [127:0] acc;
		logic [63:0] r2, u1, u2, t, hmag, emag, w, k, v;
		logic hneg, eneg, in_cut, rv;
		logic [47:0] f[3], e;
		force_res_t r;
		d[0] = {p.bx[31], p.bx} - {p.ax[31], p.ax};
		d[1] = {p.by[31], p.by} - {p.ay[31], p.ay};
		d[2] = {p.bz[31], p.bz} - {p.az[31], p.az};
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			m[i] = {31'b0, d[i][32] ? -d[i] : d[i]};
			acc += {64'b0, m[i]} * {64'b0, m[i]};
			f[i] = '0;
		end
		r2 = 64'(acc >> 16);
		e = '0;
		in_cut = (r2 != 0) && (r2 <= {16'b0, cut_q});
		if (in_cut) begin
			u1 = div_sat({16'b0, s6_q}, lcpf_pkg::ONE_Q32, r2);
			u2 = div_sat(u1, lcpf_pkg::ONE_Q16, r2);
			t = div_sat(u2, lcpf_pkg::ONE_Q16, r2);
			if (t[63]) begin
				hmag = '1;
				hneg = 1'b0;
			end else if (2 * t >= lcpf_pkg::ONE_Q32) begin
				hmag = 2 * t - lcpf_pkg::ONE_Q32;
				hneg = 1'b0;
			end else begin
				hmag = lcpf_pkg::ONE_Q32 - 2 * t;
				hneg = 1'b1;
			end
			eneg = t < lcpf_pkg::ONE_Q32;
			emag = eneg ? lcpf_pkg::ONE_Q32 - t : t - lcpf_pkg::ONE_Q32;
			w = mul_shift(t, hmag, 40);
			k = mul_shift({32'b0, eps_q}, w, 16);
			k = (k > lcpf_pkg::K24_LIM) ? '1 : k * 24;
			for (int i = 0; i < 3; i++)
				f[i] = sat_acc(div_sat(k, m[i], r2), hneg == d[i][32]);
			v = mul_shift(t, emag, 40);
			e = sat_acc(mul_shift({32'b0, eps_q}, v, 15), eneg);
			sum_fx = add_sat(sum_fx, f[0]);
			sum_fy = add_sat(sum_fy, f[1]);
			sum_fz = add_sat(sum_fz, f[2]);
			sum_e = add_sat(sum_e, e);
		end
		rv = in_cut && half_q;
		r.idx = p.idx;
		r.rfx = rv ? f[0] : '0;
		r.rfy = rv ? f[1] : '0;
		r.rfz = rv ? f[2] : '0;
		r.energy = e;
		r.rvalid = rv;
		r.tfx = sum_fx;
		r.tfy = sum_fy;
		r.tfz = sum_fz;
		r.tenergy = sum_e;
		r.done = p.last;
		if (p.last) begin
			sum_fx = '0;
			sum_fy = '0;
			sum_fz = '0;
			sum_e = '0;
		end
		return r;
	endfunction

	// pair driver
	pair_t cur_pair;
	int send_gap = 0;
	logic send_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			pin.valid <= 1'b0;
			pin.atom_x <= '0;
			pin.atom_y <= '0;
			pin.atom_z <= '0;
			pin.nb_x <= '0;
			pin.nb_y <= '0;
			pin.nb_z <= '0;
			pin.nb_index <= '0;
			pin.last_neighbour <= 1'b0;
		end else begin
			nv = pin.valid;
			if (pin.valid && pin.ready) begin
				expected_forces.push_back(pair_force(cur_pair));
				nv = 1'b0;
				if ($urandom_range(0, 15) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(0, 18);
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_pairs.size() > 0) begin
					cur_pair = pending_pairs.pop_front();
					pin.atom_x <= cur_pair.ax;
					pin.atom_y <= cur_pair.ay;
					pin.atom_z <= cur_pair.az;
					pin.nb_x <= cur_pair.bx;
					pin.nb_y <= cur_pair.by;
					pin.nb_z <= cur_pair.bz;
					pin.nb_index <= cur_pair.idx;
					pin.last_neighbour <= cur_pair.last;
					nv = 1'b1;
				end
			end
			pin.valid <= nv;
		end
	end

	// result monitor with random back-pressure
	int stall = 0;
	logic recv_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		force_res_t got, want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				got = {res.out_nb_index, res.react_fx, res.react_fy, res.react_fz,
					res.pair_energy, res.react_valid, res.total_fx, res.total_fy,
					res.total_fz, res.total_energy, res.atom_done};
				if (expected_forces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", got);
				end else begin
					want = expected_forces.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch\n  expected %p\n  actual   %p", want, got);
					end
				end
				if ($urandom_range(0, 15) == 0)
					recv_burst = !recv_burst;
				stall = recv_burst ? 0 : $urandom_range(0, 18);
			end
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [63:0] val);
		@(posedge clk);
		cfgw.valid <= 1'b1;
		cfgw.index <= idx;
		cfgw.data <= val;
		do
			@(posedge clk);
		while (!(cfgw.valid && cfgw.ready));
		cfgw.valid <= 1'b0;
		case (idx)
			lcpf_pkg::CFG_EPSILON: eps_q = val[31:0];
			lcpf_pkg::CFG_SIGMA_POW6: s6_q = val[47:0];
			lcpf_pkg::CFG_CUTOFF_SQ: cut_q = val[47:0];
			lcpf_pkg::CFG_HALF_LIST: half_q = val[0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] e, logic [47:0] s6, logic [47:0] cut, logic half);
		write_reg(lcpf_pkg::CFG_EPSILON, {32'b0, e});
		write_reg(lcpf_pkg::CFG_SIGMA_POW6, {16'b0, s6});
		write_reg(lcpf_pkg::CFG_CUTOFF_SQ, {16'b0, cut});
		write_reg(lcpf_pkg::CFG_HALF_LIST, {63'b0, half});
	endtask

	// sample away from the rising edge so the driver's updates have settled
	task automatic drain();
		do
			@(negedge clk);
		while (pending_pairs.size() > 0 || pin.valid || expected_forces.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic void add_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
		logic [31:0] bx, logic [31:0] by, logic [31:0] bz, logic [15:0] idx, logic last);
		pair_t p;
		p.ax = ax; p.ay = ay; p.az = az;
		p.bx = bx; p.by = by; p.bz = bz;
		p.idx = idx;
		p.last = last;
		pending_pairs.push_back(p);
	endfunction

	function automatic logic [31:0] offset(logic [31:0] base, int span);
		return base + 32'($urandom_range(0, 2 * span) - span);
	endfunction

	// mostly near neighbours, some coincident pairs and far noise
	function automatic void add_random_pairs(int n);
		logic [31:0] ax, ay, az;
		int kind, span;
		for (int i = 0; i < n; i++) begin
			ax = $urandom();
			ay = $urandom();
			az = $urandom();
			kind = $urandom_range(0, 9);
			span = ($urandom_range(0, 4) == 0) ? 4096 : SPAN;
			if (kind == 0)
				add_pair(ax, ay, az, $urandom(), $urandom(), $urandom(),
					16'($urandom()), $urandom_range(0, 5) == 0);
			else if (kind == 1)
				add_pair(ax, ay, az, ax, ay, az, 16'($urandom()),
					$urandom_range(0, 5) == 0);
			else
				add_pair(ax, ay, az, offset(ax, span), offset(ay, span), offset(az, span),
					16'($urandom()), $urandom_range(0, 5) == 0);
		end
	endfunction

	initial begin
		cfgw.valid = 1'b0;
		cfgw.index = '0;
		cfgw.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, coincident pair, out of range, near pairs, last flags
		add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
		add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 1'b1);
		add_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 16'h1234, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 16'h1, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 16'h2, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_2000, 16'h3, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0002_8000, 32'h0, 32'h0, 16'h4, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0002_8001, 32'h0, 32'h0, 16'h5, 1'b1);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0, 16'h6, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0000_0100, 32'h0000_0100, 32'h0, 16'h7, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8, 1'b1);
		add_pair(32'hFFFF_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 16'h9, 1'b1);
		add_random_pairs(140);
		drain();

		set_regs(32'h0001_8000, 48'h0000_0000_8000, 48'h0000_0006_4000, 1'b1);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 16'hA5A5, 1'b0);
		add_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h5A5A, 1'b1);
		add_random_pairs(170);
		drain();

		set_regs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
		add_random_pairs(160);
		drain();

		set_regs(32'h0, 48'h0, 48'h0, 1'b0);
		add_random_pairs(140);
		drain();

		set_regs($urandom(), {16'b0, $urandom_range(1, 32'h0040_0000)},
			{16'b0, $urandom_range(1, 32'h0010_0000)}, 1'($urandom_range(0, 1)));
		add_random_pairs(160);
		drain();

		set_regs(32'h0001_0000, 48'h0000_0001_0000, 48'h0000_0006_4000, 1'b1);
		add_random_pairs(160);
		drain();

		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_forces.size() == 0)
			$display("lj_cutoff_pair_force_test passed");
		else
			$display("lj_cutoff_pair_force_test failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("lj_cutoff_pair_force_test failed");
		$finish;
	end

endmodule
`default_nettype wire
